// ===== sv/pae_pkg.sv =====
`default_nettype none

package pae_pkg;

    // Archive geometry
    localparam int NUM_ENTRIES = 64;
    localparam int NUM_OBJ     = 3;
    localparam int VALUE_BITS  = 32;
    localparam int TAG_BITS    = 16;

    // Lanes work side by side, each on its own bank of the archive
    localparam int NUM_LANES  = 4;
    localparam int BANK_DEPTH = NUM_ENTRIES / NUM_LANES;
    localparam int LANE_W     = $clog2(NUM_LANES);
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int ENTRY_W    = $clog2(NUM_ENTRIES);
    localparam int CNT_W      = $clog2(NUM_ENTRIES + 1);

    // Port field widths
    localparam int IN_OBJ_W  = 32;
    localparam int IN_TAG_W  = 16;
    localparam int SLOT_W    = 6;
    localparam int ENERGY_W  = 8;
    localparam int VERDICT_W = 2;
    localparam int SIZE_W    = 7;

    // Action codes
    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VD_APPENDED  = 2'd0;
    localparam logic [VERDICT_W-1:0] VD_DOMINATED = 2'd1;
    localparam logic [VERDICT_W-1:0] VD_REPLACED  = 2'd2;
    localparam logic [VERDICT_W-1:0] VD_DROPPED   = 2'd3;

    typedef logic [NUM_OBJ-1:0][VALUE_BITS-1:0] t_obj_vec;

    typedef struct packed {
        t_obj_vec            objs;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // What one lane found for one stored entry
    typedef struct packed {
        logic dom;
        logic kill;
        logic free;
    } t_lane_flags;

    // Running totals of one scan
    typedef struct packed {
        logic [CNT_W-1:0]   dom_cnt;
        logic [CNT_W-1:0]   rem_cnt;
        logic               has_kill;
        logic [ENTRY_W-1:0] first_kill;
        logic               has_free;
        logic [ENTRY_W-1:0] first_free;
    } t_scan_sum;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_READ,
        S_RDATA
    } t_state;

endpackage

`default_nettype wire

// ===== sv/pae_in_if.sv =====
`default_nettype none

interface pae_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    action;
    logic signed [pae_pkg::IN_OBJ_W-1:0]     obj_a;
    logic signed [pae_pkg::IN_OBJ_W-1:0]     obj_b;
    logic signed [pae_pkg::IN_OBJ_W-1:0]     obj_c;
    logic        [pae_pkg::IN_TAG_W-1:0]     cand_tag;
    logic        [pae_pkg::SLOT_W-1:0]       slot;

    modport source (
        output valid, action, obj_a, obj_b, obj_c, cand_tag, slot,
        input  ready
    );

    modport sink (
        input  valid, action, obj_a, obj_b, obj_c, cand_tag, slot,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pae_out_if.sv =====
`default_nettype none

interface pae_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pae_pkg::ENERGY_W-1:0]     energy;
    logic        [pae_pkg::VERDICT_W-1:0]    verdict;
    logic        [pae_pkg::SIZE_W-1:0]       archive_size;
    logic                                    read_valid;
    logic signed [pae_pkg::IN_OBJ_W-1:0]     read_obj_a;
    logic signed [pae_pkg::IN_OBJ_W-1:0]     read_obj_b;
    logic signed [pae_pkg::IN_OBJ_W-1:0]     read_obj_c;
    logic        [pae_pkg::IN_TAG_W-1:0]     read_tag;

    modport source (
        output valid, energy, verdict, archive_size, read_valid,
               read_obj_a, read_obj_b, read_obj_c, read_tag,
        input  ready
    );

    modport sink (
        input  valid, energy, verdict, archive_size, read_valid,
               read_obj_a, read_obj_b, read_obj_c, read_tag,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pareto_archive_engine_core.sv =====
`default_nettype none
// Offer: the scan reads one bank row per cycle over the 4 lanes, the drain state
// lets the lane and merge registers empty, and commit places the candidate and
// registers the result. Read: a read state, then a data state registers the entry.
// One item at a time; a finished result waits in an output register.
// Reset (synchronous, active low) empties the archive: all slots invalid,
// count zero. Stored objectives and tags are not cleared.

module pareto_archive_engine_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pae_in_if.sink       i_in,
    pae_out_if.source    o_out
);

    pae_pkg::t_state                       r_state;
    pae_pkg::t_state                       n_state;

    logic [pae_pkg::NUM_ENTRIES-1:0]       r_valid;
    logic [pae_pkg::CNT_W-1:0]             r_count;

    pae_pkg::t_entry                       r_cand;
    logic [pae_pkg::ENTRY_W-1:0]           r_slot;
    logic                                  r_slot_ok;

    logic [pae_pkg::ADDR_W-1:0]            r_idx;
    logic [pae_pkg::ADDR_W-1:0]            r_idx_d1;
    logic [pae_pkg::ADDR_W-1:0]            r_idx_d2;
    logic                                  r_v1;
    logic                                  r_v2;

    logic                                  r_out_valid;
    logic signed [pae_pkg::ENERGY_W-1:0]   r_energy;
    logic [pae_pkg::VERDICT_W-1:0]         r_verdict;
    logic [pae_pkg::SIZE_W-1:0]            r_size;
    logic                                  r_rd_valid;
    logic signed [pae_pkg::IN_OBJ_W-1:0]   r_rd_a;
    logic signed [pae_pkg::IN_OBJ_W-1:0]   r_rd_b;
    logic signed [pae_pkg::IN_OBJ_W-1:0]   r_rd_c;
    logic [pae_pkg::IN_TAG_W-1:0]          r_rd_tag;

    pae_pkg::t_entry                       n_cand;
    logic                                  w_accept;
    logic                                  w_out_free;
    logic                                  w_in_ready;
    logic                                  w_clear;
    logic                                  w_read_mode;
    logic                                  w_commit;
    logic                                  w_rd_done;
    logic [pae_pkg::ADDR_W-1:0]            w_rd_addr;

    pae_pkg::t_scan_sum                    w_sum;
    logic [pae_pkg::NUM_ENTRIES-1:0]       w_kill;
    pae_pkg::t_lane_flags                  w_flags [pae_pkg::NUM_LANES];
    pae_pkg::t_entry                       w_lane_rd [pae_pkg::NUM_LANES];
    logic [pae_pkg::NUM_LANES-1:0]         w_lane_valid;
    logic [pae_pkg::NUM_LANES-1:0]         w_wr_en;

    logic                                  w_is_dom;
    logic                                  w_is_kill;
    logic                                  w_is_free;
    logic [pae_pkg::ENTRY_W-1:0]           w_target;
    pae_pkg::t_entry                       w_rd_entry;
    logic                                  w_rd_hit;

    assign w_accept   = i_in.valid & w_in_ready;
    assign w_out_free = ~r_out_valid | o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pae_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.action == pae_pkg::ACT_READ) ?
                              pae_pkg::S_READ : pae_pkg::S_SCAN;
                end
            end
            pae_pkg::S_SCAN: begin
                if (r_idx == pae_pkg::ADDR_W'(pae_pkg::BANK_DEPTH - 1)) begin
                    n_state = pae_pkg::S_DRAIN;
                end
            end
            pae_pkg::S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = pae_pkg::S_COMMIT;
                end
            end
            pae_pkg::S_COMMIT: begin
                if (w_out_free) begin
                    n_state = pae_pkg::S_IDLE;
                end
            end
            pae_pkg::S_READ: begin
                n_state = pae_pkg::S_RDATA;
            end
            pae_pkg::S_RDATA: begin
                if (w_out_free) begin
                    n_state = pae_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pae_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_read_mode = 1'b0;
        w_commit    = 1'b0;
        w_rd_done   = 1'b0;
        unique case (r_state)
            pae_pkg::S_IDLE:   w_in_ready  = 1'b1;
            pae_pkg::S_SCAN:   w_read_mode = 1'b0;
            pae_pkg::S_DRAIN:  w_read_mode = 1'b0;
            pae_pkg::S_COMMIT: w_commit    = w_out_free;
            pae_pkg::S_READ:   w_read_mode = 1'b1;
            pae_pkg::S_RDATA: begin
                w_read_mode = 1'b1;
                w_rd_done   = w_out_free;
            end
            default:           w_in_ready  = 1'b0;
        endcase
    end

    assign w_clear   = w_accept;
    assign w_rd_addr = w_read_mode ? r_slot[pae_pkg::ENTRY_W-1:pae_pkg::LANE_W] : r_idx;

    // Candidate as stored: objectives beyond the third are zero
    always_comb begin
        for (int i = 0; i < pae_pkg::NUM_OBJ; i++) begin
            if (i == 0) begin
                n_cand.objs[i] = pae_pkg::VALUE_BITS'(i_in.obj_a);
            end else if (i == 1) begin
                n_cand.objs[i] = pae_pkg::VALUE_BITS'(i_in.obj_b);
            end else if (i == 2) begin
                n_cand.objs[i] = pae_pkg::VALUE_BITS'(i_in.obj_c);
            end else begin
                n_cand.objs[i] = '0;
            end
        end
        n_cand.tag = pae_pkg::TAG_BITS'(i_in.cand_tag);
    end

    // Lanes
    for (genvar l = 0; l < pae_pkg::NUM_LANES; l++) begin : g_lane
        assign w_lane_valid[l] = r_valid[{r_idx_d1, pae_pkg::LANE_W'(l)}];
        assign w_wr_en[l]      = w_commit & (w_is_kill | w_is_free) &
                                 (w_target[pae_pkg::LANE_W-1:0] == pae_pkg::LANE_W'(l));

        pae_lane u_lane (
            .i_clk        (i_clk),
            .i_rd_addr    (w_rd_addr),
            .i_wr_en      (w_wr_en[l]),
            .i_wr_addr    (w_target[pae_pkg::ENTRY_W-1:pae_pkg::LANE_W]),
            .i_wr_data    (r_cand),
            .i_cand       (r_cand.objs),
            .i_slot_valid (w_lane_valid[l]),
            .o_rd_data    (w_lane_rd[l]),
            .o_flags      (w_flags[l])
        );
    end

    pae_merge u_merge (
        .i_clk   (i_clk),
        .i_clear (w_clear),
        .i_en    (r_v2),
        .i_idx   (r_idx_d2),
        .i_flags (w_flags),
        .o_sum   (w_sum),
        .o_kill  (w_kill)
    );

    // Outcome of the scan
    assign w_is_dom  = (w_sum.dom_cnt != '0);
    assign w_is_kill = ~w_is_dom & w_sum.has_kill;
    assign w_is_free = ~w_is_dom & ~w_sum.has_kill & w_sum.has_free;
    assign w_target  = w_is_kill ? w_sum.first_kill : w_sum.first_free;

    // Read path
    assign w_rd_entry = w_lane_rd[r_slot[pae_pkg::LANE_W-1:0]];
    assign w_rd_hit   = r_slot_ok & r_valid[r_slot];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pae_pkg::S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == pae_pkg::S_SCAN);
            r_v2    <= r_v1;

            // Advance the scan row
            if (w_accept) begin
                r_idx <= '0;
            end else if (r_state == pae_pkg::S_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end

            // Drop dominated entries and place the candidate
            if (w_commit) begin
                if (w_is_kill) begin
                    r_valid           <= (r_valid & ~w_kill) |
                                         (pae_pkg::NUM_ENTRIES'(1) << w_target);
                    r_count           <= r_count - w_sum.rem_cnt + 1'b1;
                end else if (w_is_free) begin
                    r_valid[w_target] <= 1'b1;
                    r_count           <= r_count + 1'b1;
                end
            end

            if (w_commit || w_rd_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx_d1 <= r_idx;
        r_idx_d2 <= r_idx_d1;

        if (w_accept) begin
            r_cand    <= n_cand;
            r_slot    <= pae_pkg::ENTRY_W'(i_in.slot);
            r_slot_ok <= (32'(i_in.slot) < 32'(pae_pkg::NUM_ENTRIES));
        end

        // Result of an offer
        if (w_commit) begin
            r_rd_valid <= 1'b0;
            r_rd_a     <= '0;
            r_rd_b     <= '0;
            r_rd_c     <= '0;
            r_rd_tag   <= '0;
            if (w_is_dom) begin
                r_energy  <= (32'(w_sum.dom_cnt) > 127) ? 8'sd127 :
                             pae_pkg::ENERGY_W'(w_sum.dom_cnt);
                r_verdict <= pae_pkg::VD_DOMINATED;
                r_size    <= pae_pkg::SIZE_W'(r_count);
            end else if (w_is_kill) begin
                r_energy  <= (32'(w_sum.rem_cnt) > 128) ? -8'sd128 :
                             pae_pkg::ENERGY_W'(32'sd0 - 32'(w_sum.rem_cnt));
                r_verdict <= pae_pkg::VD_REPLACED;
                r_size    <= pae_pkg::SIZE_W'(r_count - w_sum.rem_cnt + 1'b1);
            end else if (w_is_free) begin
                r_energy  <= '0;
                r_verdict <= pae_pkg::VD_APPENDED;
                r_size    <= pae_pkg::SIZE_W'(r_count + 1'b1);
            end else begin
                r_energy  <= '0;
                r_verdict <= pae_pkg::VD_DROPPED;
                r_size    <= pae_pkg::SIZE_W'(r_count);
            end
        end

        // Result of a read
        if (w_rd_done) begin
            r_energy   <= '0;
            r_verdict  <= pae_pkg::VD_APPENDED;
            r_size     <= pae_pkg::SIZE_W'(r_count);
            r_rd_valid <= w_rd_hit;
            r_rd_a     <= w_rd_hit ? pae_pkg::IN_OBJ_W'($signed(w_rd_entry.objs[0])) : '0;
            r_rd_b     <= w_rd_hit ? pae_pkg::IN_OBJ_W'($signed(w_rd_entry.objs[1])) : '0;
            if (pae_pkg::NUM_OBJ > 2) begin
                r_rd_c <= w_rd_hit ?
                          pae_pkg::IN_OBJ_W'($signed(
                              w_rd_entry.objs[(pae_pkg::NUM_OBJ > 2) ? 2 : 0])) : '0;
            end else begin
                r_rd_c <= '0;
            end
            r_rd_tag   <= w_rd_hit ? pae_pkg::IN_TAG_W'(w_rd_entry.tag) : '0;
        end
    end

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.energy        = r_energy;
    assign o_out.verdict       = r_verdict;
    assign o_out.archive_size  = r_size;
    assign o_out.read_valid    = r_rd_valid;
    assign o_out.read_obj_a    = r_rd_a;
    assign o_out.read_obj_b    = r_rd_b;
    assign o_out.read_obj_c    = r_rd_c;
    assign o_out.read_tag      = r_rd_tag;

endmodule

`default_nettype wire

// ===== sv/pae_lane.sv =====
`default_nettype none

module pae_lane (
    input  wire logic                         i_clk,
    input  wire logic [pae_pkg::ADDR_W-1:0]   i_rd_addr,
    input  wire logic                         i_wr_en,
    input  wire logic [pae_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire pae_pkg::t_entry              i_wr_data,
    input  wire pae_pkg::t_obj_vec            i_cand,
    input  wire logic                         i_slot_valid,
    output pae_pkg::t_entry                   o_rd_data,
    output pae_pkg::t_lane_flags              o_flags
);

    pae_pkg::t_entry      r_bank [pae_pkg::BANK_DEPTH];
    pae_pkg::t_entry      r_rd_data;
    pae_pkg::t_lane_flags r_flags;
    pae_pkg::t_lane_flags n_flags;

    // Bank of this lane: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_bank[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_bank[i_rd_addr];
    end

    // Compare the stored entry with the candidate
    always_comb begin
        logic stored_le;
        logic cand_le;
        logic cand_lt;
        stored_le = 1'b1;
        cand_le   = 1'b1;
        cand_lt   = 1'b0;
        for (int i = 0; i < pae_pkg::NUM_OBJ; i++) begin
            if ($signed(r_rd_data.objs[i]) > $signed(i_cand[i])) begin
                stored_le = 1'b0;
            end
            if ($signed(i_cand[i]) > $signed(r_rd_data.objs[i])) begin
                cand_le = 1'b0;
            end
            if ($signed(i_cand[i]) < $signed(r_rd_data.objs[i])) begin
                cand_lt = 1'b1;
            end
        end
        n_flags.dom  = i_slot_valid & stored_le;
        n_flags.kill = i_slot_valid & ~stored_le & cand_le & cand_lt;
        n_flags.free = ~i_slot_valid;
    end

    // Hold the verdict of this entry for the merge stage
    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
    end

    assign o_rd_data = r_rd_data;
    assign o_flags   = r_flags;

endmodule

`default_nettype wire

// ===== sv/pae_merge.sv =====
`default_nettype none

module pae_merge (
    input  wire logic                          i_clk,
    input  wire logic                          i_clear,
    input  wire logic                          i_en,
    input  wire logic [pae_pkg::ADDR_W-1:0]    i_idx,
    input  wire pae_pkg::t_lane_flags          i_flags [pae_pkg::NUM_LANES],
    output pae_pkg::t_scan_sum                 o_sum,
    output logic [pae_pkg::NUM_ENTRIES-1:0]    o_kill
);

    pae_pkg::t_scan_sum                r_sum;
    pae_pkg::t_scan_sum                n_sum;
    logic [pae_pkg::NUM_ENTRIES-1:0]   r_kill;
    logic [pae_pkg::NUM_ENTRIES-1:0]   n_kill;

    // Fold this cycle's lanes into the totals, lowest lane first
    always_comb begin
        logic [pae_pkg::ENTRY_W-1:0] ent;
        n_sum  = r_sum;
        n_kill = r_kill;
        ent    = '0;
        if (i_clear) begin
            n_sum  = '0;
            n_kill = '0;
        end else if (i_en) begin
            for (int l = 0; l < pae_pkg::NUM_LANES; l++) begin
                ent = {i_idx, pae_pkg::LANE_W'(l)};
                if (i_flags[l].dom) begin
                    n_sum.dom_cnt = n_sum.dom_cnt + 1'b1;
                end
                if (i_flags[l].kill) begin
                    n_sum.rem_cnt = n_sum.rem_cnt + 1'b1;
                    n_kill[ent]   = 1'b1;
                    if (!n_sum.has_kill) begin
                        n_sum.has_kill   = 1'b1;
                        n_sum.first_kill = ent;
                    end
                end
                if (i_flags[l].free && !n_sum.has_free) begin
                    n_sum.has_free   = 1'b1;
                    n_sum.first_free = ent;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_kill <= n_kill;
    end

    assign o_sum  = r_sum;
    assign o_kill = r_kill;

endmodule

`default_nettype wire

// ===== tb/sv/archive_checker.sv =====
`timescale 1ns / 100ps

module archive_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    pae_in_if                                i_req_mon,
    pae_out_if                               i_rsp_mon,
    output logic [31:0]                      o_fail_count,
    output logic [31:0]                      o_pending,
    output logic [pae_pkg::NUM_ENTRIES-1:0]  o_written
);

    typedef struct packed {
        logic signed [pae_pkg::ENERGY_W-1:0] energy;
        logic [pae_pkg::VERDICT_W-1:0]       verdict;
        logic [pae_pkg::SIZE_W-1:0]          occupancy;
        logic                                rd_valid;
        logic [pae_pkg::IN_OBJ_W-1:0]        rd_a;
        logic [pae_pkg::IN_OBJ_W-1:0]        rd_b;
        logic [pae_pkg::IN_OBJ_W-1:0]        rd_c;
        logic [pae_pkg::IN_TAG_W-1:0]        rd_tag;
    } t_outcome;

    // Shadow copy of the archive
    pae_pkg::t_obj_vec               front_objs [pae_pkg::NUM_ENTRIES];
    logic [pae_pkg::TAG_BITS-1:0]    front_tags [pae_pkg::NUM_ENTRIES];
    logic [pae_pkg::NUM_ENTRIES-1:0] front_live;
    logic [pae_pkg::NUM_ENTRIES-1:0] ever_written;
    int unsigned                     front_size;
    t_outcome                        due_results [$];
    int unsigned                     mismatches;

    assign o_fail_count = mismatches;

    // x is no worse than y in every objective
    function automatic logic no_worse(pae_pkg::t_obj_vec x, pae_pkg::t_obj_vec y);
        for (int k = 0; k < pae_pkg::NUM_OBJ; k++) begin
            if ($signed(x[k]) > $signed(y[k])) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one item to the shadow archive and return the result it must produce
    function automatic t_outcome archive_outcome(logic act, pae_pkg::t_obj_vec cand,
                                                 logic [pae_pkg::TAG_BITS-1:0] tag,
                                                 logic [pae_pkg::SLOT_W-1:0] slot);
        t_outcome                        res;
        int unsigned                     dom_cnt;
        int unsigned                     rem_cnt;
        int                              first_kill;
        int                              first_free;
        int                              dest;
        logic [pae_pkg::NUM_ENTRIES-1:0] doomed;
        res        = '0;
        dom_cnt    = 0;
        rem_cnt    = 0;
        first_kill = -1;
        first_free = -1;
        dest       = -1;
        doomed     = '0;
        if (act == pae_pkg::ACT_READ) begin
            if (front_live[slot]) begin
                res.rd_valid = 1'b1;
                res.rd_a     = front_objs[slot][0];
                res.rd_b     = front_objs[slot][1];
                res.rd_c     = front_objs[slot][2];
                res.rd_tag   = front_tags[slot];
            end
        end else begin
            // classify every stored entry against the candidate
            for (int e = 0; e < pae_pkg::NUM_ENTRIES; e++) begin
                if (!front_live[e]) begin
                    if (first_free < 0) first_free = e;
                end else if (no_worse(front_objs[e], cand)) begin
                    dom_cnt++;
                end else if (no_worse(cand, front_objs[e])) begin
                    // strict: the equal case was taken by the branch above
                    doomed[e] = 1'b1;
                    rem_cnt++;
                    if (first_kill < 0) first_kill = e;
                end
            end
            if (dom_cnt != 0) begin
                res.energy  = (dom_cnt > 127) ? 8'd127 : 8'(dom_cnt);
                res.verdict = pae_pkg::VD_DOMINATED;
            end else if (first_kill >= 0) begin
                front_live  = front_live & ~doomed;
                front_size  = front_size - rem_cnt + 1;
                res.energy  = (rem_cnt > 128) ? 8'h80 : 8'(0 - rem_cnt);
                res.verdict = pae_pkg::VD_REPLACED;
                dest        = first_kill;
            end else if (first_free >= 0) begin
                front_size  = front_size + 1;
                res.verdict = pae_pkg::VD_APPENDED;
                dest        = first_free;
            end else begin
                res.verdict = pae_pkg::VD_DROPPED;
            end
            if (dest >= 0) begin
                front_objs[dest]   = cand;
                front_tags[dest]   = tag;
                front_live[dest]   = 1'b1;
                ever_written[dest] = 1'b1;
            end
        end
        res.occupancy = front_size[pae_pkg::SIZE_W-1:0];
        return res;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome          got;
        t_outcome          want;
        t_outcome          fresh;
        pae_pkg::t_obj_vec cand;
        if (!i_rst_n) begin
            front_live   = '0;
            ever_written = '0;
            front_size   = 0;
            mismatches   = 0;
            due_results.delete();
        end else begin
            // compare a delivered item with the oldest prediction
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got.energy    = i_rsp_mon.energy;
                got.verdict   = i_rsp_mon.verdict;
                got.occupancy = i_rsp_mon.archive_size;
                got.rd_valid  = i_rsp_mon.read_valid;
                got.rd_a      = i_rsp_mon.read_obj_a;
                got.rd_b      = i_rsp_mon.read_obj_b;
                got.rd_c      = i_rsp_mon.read_obj_c;
                got.rd_tag    = i_rsp_mon.read_tag;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing outstanding, actual %h", $time, got);
                end else begin
                    want = due_results.pop_front();
                    check_field("energy", want.energy, got.energy);
                    check_field("verdict", want.verdict, got.verdict);
                    check_field("archive_size", want.occupancy, got.occupancy);
                    check_field("read_valid", want.rd_valid, got.rd_valid);
                    check_field("read_obj_a", want.rd_a, got.rd_a);
                    check_field("read_obj_b", want.rd_b, got.rd_b);
                    check_field("read_obj_c", want.rd_c, got.rd_c);
                    check_field("read_tag", want.rd_tag, got.rd_tag);
                end
            end
            // predict each accepted item
            if (i_req_mon.valid && i_req_mon.ready) begin
                cand[0] = i_req_mon.obj_a;
                cand[1] = i_req_mon.obj_b;
                cand[2] = i_req_mon.obj_c;
                fresh = archive_outcome(i_req_mon.action, cand,
                                        i_req_mon.cand_tag, i_req_mon.slot);
                due_results = {due_results, fresh};
            end
        end
        o_pending <= due_results.size();
        o_written <= ever_written;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int          RANDOM_ITEMS = 800;
    localparam int          QUIET_TAIL   = 120;
    localparam logic [31:0] EPOCH_STEP   = 32'd400_000_000;
    localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] NEAR_TOP     = 32'h7FFF_0000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic [31:0]                     fail_count;
    logic [31:0]                     pending;
    logic [pae_pkg::NUM_ENTRIES-1:0] written_slots;
    logic                            idle_enable;
    int                              gap_pct;
    int                              stall_pct;

    pae_in_if  offer_ch ();
    pae_out_if result_ch ();

    pareto_archive_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (offer_ch),
        .o_out   (result_ch)
    );

    archive_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (offer_ch),
        .i_rsp_mon    (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_written    (written_slots)
    );

    always #2 i_clk = ~i_clk;

    // Hold valid until the block takes the item, with optional idle cycles first
    task automatic present_item(logic act, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                logic [15:0] tag, logic [5:0] slot);
        if (idle_enable && $urandom_range(0, 99) < gap_pct) begin
            offer_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        offer_ch.valid    <= 1'b1;
        offer_ch.action   <= act;
        offer_ch.obj_a    <= a;
        offer_ch.obj_b    <= b;
        offer_ch.obj_c    <= c;
        offer_ch.cand_tag <= tag;
        offer_ch.slot     <= slot;
        @(posedge i_clk);
        while (!offer_ch.ready) @(posedge i_clk);
    endtask

    task automatic offer_vec(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [15:0] tag);
        present_item(pae_pkg::ACT_OFFER, a, b, c, tag, 6'($urandom));
    endtask

    task automatic read_slot(logic [5:0] slot);
        present_item(pae_pkg::ACT_READ, $urandom, $urandom, $urandom, 16'($urandom), slot);
    endtask

    // Pick a slot that has held an entry at some point, or -1 if none has
    function automatic int pick_read_slot();
        int start;
        start = $urandom_range(0, pae_pkg::NUM_ENTRIES - 1);
        for (int k = 0; k < pae_pkg::NUM_ENTRIES; k++) begin
            if (written_slots[(start + k) % pae_pkg::NUM_ENTRIES])
                return (start + k) % pae_pkg::NUM_ENTRIES;
        end
        return -1;
    endfunction

    // Result side: stall ready in short bursts
    initial begin
        result_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_enable && $urandom_range(0, 99) < stall_pct) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        logic [31:0] base;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [5:0]  slot;
        logic        act;
        int          span;
        int          run_len;
        int          pick;
        int          x;
        int          rd;
        int          sent;
        int          epoch;

        idle_enable       = 1'b1;
        gap_pct           = 20;
        stall_pct         = 20;
        i_rst_n           <= 1'b0;
        offer_ch.valid    <= 1'b0;
        offer_ch.action   <= pae_pkg::ACT_OFFER;
        offer_ch.obj_a    <= '0;
        offer_ch.obj_b    <= '0;
        offer_ch.obj_c    <= '0;
        offer_ch.cand_tag <= '0;
        offer_ch.slot     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: equal vectors, multi-entry domination, removal, extremes
        offer_vec(NEAR_TOP, NEAR_TOP, NEAR_TOP, 16'h0000);
        offer_vec(NEAR_TOP, NEAR_TOP, NEAR_TOP, 16'hFFFF);
        read_slot(6'd0);
        offer_vec(NEAR_TOP + 16, NEAR_TOP - 16, NEAR_TOP, 16'h1234);
        offer_vec(NEAR_TOP - 16, NEAR_TOP + 16, NEAR_TOP, 16'hA5A5);
        offer_vec(VAL_MAX, VAL_MAX, VAL_MAX, 16'h5A5A);
        offer_vec(NEAR_TOP - 16, NEAR_TOP - 16, NEAR_TOP - 1, 16'h0F0F);
        read_slot(6'd1);
        read_slot(6'd0);
        offer_vec(VAL_MIN, VAL_MAX, VAL_MAX, 16'h8001);
        offer_vec(VAL_MAX, VAL_MIN, VAL_MAX, 16'h7FFE);
        offer_vec(VAL_MIN, VAL_MIN, VAL_MAX, 16'hFFFF);
        offer_vec(VAL_MAX, VAL_MAX, VAL_MIN, 16'h0001);
        read_slot(6'd1);
        read_slot(6'd2);

        // Random: each epoch builds a front below the previous one, which it sweeps away
        sent  = 0;
        epoch = 0;
        while (sent < RANDOM_ITEMS) begin
            base      = VAL_MAX - 32'(epoch + 1) * EPOCH_STEP;
            span      = ($urandom_range(0, 2) == 0) ? $urandom_range(70, 300)
                                                    : $urandom_range(4096, 1 << 24);
            run_len   = $urandom_range(70, 110);
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                if (RANDOM_ITEMS - sent <= QUIET_TAIL) idle_enable = 1'b0;
                pick = $urandom_range(0, 99);
                x    = $urandom_range(0, span);
                act  = pae_pkg::ACT_OFFER;
                slot = 6'($urandom);
                a    = base + x;
                b    = base + span - x;
                c    = base + $urandom_range(0, 3);
                if (pick < 10) begin
                    rd = pick_read_slot();
                    if (rd >= 0) begin
                        act  = pae_pkg::ACT_READ;
                        slot = 6'(rd);
                        a    = $urandom;
                        b    = $urandom;
                        c    = $urandom;
                    end
                end else if (pick < 14) begin
                    // stray point: one objective anywhere, the others near the top
                    a = $urandom;
                    b = VAL_MAX - $urandom_range(0, 15);
                    c = VAL_MAX - $urandom_range(0, 15);
                end else if (pick < 20) begin
                    // behind the whole current front
                    a = base + span + 8 + $urandom_range(0, 3);
                    b = base + span + 8 + $urandom_range(0, 3);
                    c = base + 8;
                end else if (pick < 32) begin
                    // cut a band out of the front
                    b = b - $urandom_range(0, span / 8 + 1);
                    c = base;
                end else if (pick < 40) begin
                    b = b + $urandom_range(0, 6) - 3;
                end
                present_item(act, a, b, c, 16'($urandom), slot);
                sent++;
            end
            epoch++;
        end
        offer_ch.valid <= 1'b0;

        // Drain outstanding results, then allow for a stray late one
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pae_pkg.sv
sv/pae_in_if.sv
sv/pae_out_if.sv
sv/pae_lane.sv
sv/pae_merge.sv
sv/pareto_archive_engine_core.sv
tb/sv/archive_checker.sv
tb/sv/tb_top.sv
